/* hdl/upt_pkg.sv */
// Package for the unordered pair table: entry layout, operation and status codes,
// memory request bundle. Used by every module of the block; depends on nothing.
`default_nettype none

package upt_pkg;

    localparam int ATOM_W          = 12;
    localparam int ADDR_W          = 12;    // wide enough for the largest table
    localparam int INDEX_OUT_W     = 8;
    localparam int COUNT_OUT_W     = 9;
    localparam int DEF_MAX_ENTRIES = 256;

    typedef enum logic [1:0] {
        OP_FIND       = 2'd0,
        OP_ADD        = 2'd1,
        OP_DELETE     = 2'd2,
        OP_DELETE_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_DUPLICATE = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic              virt;
        logic [ATOM_W-1:0] atom_b;
        logic [ATOM_W-1:0] atom_a;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

/* hdl/upt_store.sv */
// Pair store: single-clock RAM, one write and one read port, registered read data.
// Depends on upt_pkg.
`default_nettype none

module upt_store #(
    parameter int MAX_ENTRIES = upt_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic              aclk,
    input  wire upt_pkg::mem_req_t req,
    output upt_pkg::entry_t        rd_data
);
    import upt_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    entry_t mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

/* hdl/upt_ctrl.sv */
// Sequencer for the pair table: scans the store, resolves find/add/delete/delete-all,
// moves the last entry into freed slots, and holds the result register.
// Depends on upt_pkg.
`default_nettype none

module upt_ctrl #(
    parameter int MAX_ENTRIES = upt_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire upt_pkg::op_t                        s_operation,
    input  wire logic [upt_pkg::ATOM_W-1:0]          s_atom_a,
    input  wire logic [upt_pkg::ATOM_W-1:0]          s_atom_b,
    input  wire logic                                s_virtual_flag,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output upt_pkg::status_t                         m_status,
    output logic [upt_pkg::INDEX_OUT_W-1:0]          m_bond_index,
    output logic [upt_pkg::COUNT_OUT_W-1:0]          m_removed_count,
    output logic [upt_pkg::COUNT_OUT_W-1:0]          m_bond_total,
    output upt_pkg::mem_req_t                        mem_req,
    input  wire upt_pkg::entry_t                     rd_data
);
    import upt_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MOVE = 5'b00100,
        S_END  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;

    op_t               op_reg, op_next;
    logic [ATOM_W-1:0] a_reg, a_next;
    logic [ATOM_W-1:0] b_reg, b_next;
    logic              v_reg, v_next;
    logic [IDX_W-1:0]  chk_reg, chk_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  index_reg, index_next;

    status_t                m_status_reg, m_status_next;
    logic [INDEX_OUT_W-1:0] m_index_reg, m_index_next;
    logic [COUNT_OUT_W-1:0] m_removed_reg, m_removed_next;
    logic [COUNT_OUT_W-1:0] m_total_reg, m_total_next;

    logic [CNT_W-1:0] chk_plus;
    logic [CNT_W-1:0] last_idx;
    logic             at_last;
    logic             more;
    logic             hit_pair;
    logic             hit_atom;
    logic             full;

    assign chk_plus = CNT_W'(chk_reg) + CNT_W'(1);
    assign last_idx = count_reg - CNT_W'(1);
    assign at_last  = (CNT_W'(chk_reg) == last_idx);
    assign more     = (chk_plus < count_reg);
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign hit_pair = (rd_data.atom_a == a_reg && rd_data.atom_b == b_reg) ||
                      (rd_data.atom_a == b_reg && rd_data.atom_b == a_reg);
    assign hit_atom = (rd_data.atom_a == a_reg) || (rd_data.atom_b == a_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        v_next         = v_reg;
        chk_next       = chk_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        m_status_next  = m_status_reg;
        m_index_next   = m_index_reg;
        m_removed_next = m_removed_reg;
        m_total_next   = m_total_reg;
        mem_req        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    a_next       = s_atom_a;
                    b_next       = s_atom_b;
                    v_next       = s_virtual_flag;
                    chk_next     = '0;
                    removed_next = '0;
                    status_next  = STS_OK;
                    index_next   = '0;
                    if (count_reg == '0) begin
                        state_next = S_END;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // rd_data holds the entry at chk_reg
                if (op_reg == OP_DELETE_ALL && hit_atom) begin
                    removed_next = removed_reg + CNT_W'(1);
                    if (at_last) begin
                        count_next = last_idx;
                        state_next = S_END;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ADDR_W'(last_idx);
                        state_next      = S_MOVE;
                    end
                end else if (op_reg != OP_DELETE_ALL && hit_pair) begin
                    case (op_reg)
                        OP_FIND: begin
                            index_next = chk_reg;
                            state_next = S_OUT;
                        end
                        OP_ADD: begin
                            status_next = STS_DUPLICATE;
                            state_next  = S_OUT;
                        end
                        default: begin
                            index_next   = chk_reg;
                            removed_next = CNT_W'(1);
                            if (at_last) begin
                                count_next = last_idx;
                                state_next = S_OUT;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = ADDR_W'(last_idx);
                                state_next      = S_MOVE;
                            end
                        end
                    endcase
                end else if (more) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(chk_plus);
                    chk_next        = IDX_W'(chk_plus);
                end else begin
                    state_next = S_END;
                end
            end

            S_MOVE: begin
                // last entry now in rd_data; it stays there for the recheck
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_W'(chk_reg);
                mem_req.wr_data = rd_data;
                count_next      = last_idx;
                if (op_reg == OP_DELETE_ALL) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_OUT;
                end
            end

            S_END: begin
                // scan ran out without a pair match, or delete-all finished its walk
                case (op_reg)
                    OP_FIND, OP_DELETE: begin
                        status_next = STS_NOT_FOUND;
                    end
                    OP_ADD: begin
                        if (full) begin
                            status_next = STS_FULL;
                        end else begin
                            mem_req.wr_en          = 1'b1;
                            mem_req.wr_addr        = ADDR_W'(count_reg);
                            mem_req.wr_data.atom_a = a_reg;
                            mem_req.wr_data.atom_b = b_reg;
                            mem_req.wr_data.virt   = v_reg;
                            index_next             = IDX_W'(count_reg);
                            count_next             = count_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = S_OUT;
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_index_next   = INDEX_OUT_W'(index_reg);
                    m_removed_next = COUNT_OUT_W'(removed_reg);
                    m_total_next   = COUNT_OUT_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        v_reg         <= v_next;
        chk_reg       <= chk_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        index_reg     <= index_next;
        m_status_reg  <= m_status_next;
        m_index_reg   <= m_index_next;
        m_removed_reg <= m_removed_next;
        m_total_reg   <= m_total_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_bond_index    = m_index_reg;
    assign m_removed_count = m_removed_reg;
    assign m_bond_total    = m_total_reg;

endmodule

`default_nettype wire

/* hdl/unordered_pair_table.sv */
// Unordered pair table, top level: pair store RAM plus scan sequencer.
// Depends on upt_pkg, upt_store, upt_ctrl.
//
// Usage: one word on the s_ channel is one operation (find, add, delete pair,
// delete all pairs touching s_atom_a); exactly one result word comes out on
// the m_ channel for each, in order. Both channels use valid/ready.
// Scan: an operation walks the stored entries one per cycle through the
// single read port of the pair RAM, stopping at the first match; delete-all
// walks every entry and pauses on each hit to refill the freed slot. A delete
// hit moves the last entry into the freed slot unless that slot was the last,
// and delete-all does the same for each entry it removes. s_ready returns as
// the result is loaded into the output register. One operation is in flight
// at a time; s_ready is high only between operations.
// The result sits in an output register; a new operation may be accepted
// while it waits. If the receiver stalls, the next finished result is held
// inside until the register frees up, and input stalls behind it.
// Reset (aresetn low, synchronous) empties the table; the RAM itself is not
// cleared, entries at or above the count are never read.
`default_nettype none

module unordered_pair_table #(
    parameter int MAX_ENTRIES = upt_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire upt_pkg::op_t                        s_operation,
    input  wire logic [upt_pkg::ATOM_W-1:0]          s_atom_a,
    input  wire logic [upt_pkg::ATOM_W-1:0]          s_atom_b,
    input  wire logic                                s_virtual_flag,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output upt_pkg::status_t                         m_status,
    output logic [upt_pkg::INDEX_OUT_W-1:0]          m_bond_index,
    output logic [upt_pkg::COUNT_OUT_W-1:0]          m_removed_count,
    output logic [upt_pkg::COUNT_OUT_W-1:0]          m_bond_total
);
    import upt_pkg::*;

    mem_req_t mem_req;
    entry_t   rd_data;

    upt_store #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_store (
        .aclk   (aclk),
        .req    (mem_req),
        .rd_data(rd_data)
    );

    upt_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_atom_a       (s_atom_a),
        .s_atom_b       (s_atom_b),
        .s_virtual_flag (s_virtual_flag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bond_index   (m_bond_index),
        .m_removed_count(m_removed_count),
        .m_bond_total   (m_bond_total),
        .mem_req        (mem_req),
        .rd_data        (rd_data)
    );

    // sequencer never reads and writes the RAM in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("pair RAM read and write issued together");

    // any removal reports success
    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_removed_count != '0) |-> (m_status == STS_OK))
        else $error("removal reported with a failing status");

    // failing operations report index zero and remove nothing
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STS_OK) |->
            (m_bond_index == '0 && m_removed_count == '0))
        else $error("failing operation carries index or removals");

    // a full-table result only when the table is at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STS_FULL) |->
            (m_bond_total == COUNT_OUT_W'(MAX_ENTRIES)))
        else $error("table-full result below capacity");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for unordered_pair_table: drives find/add/delete/delete-all words, predicts
// each result from a local copy of the bond table and checks the m_ channel word by word.
// Depends on upt_pkg and the unordered_pair_table RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import upt_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;

    typedef struct {
        status_t                status;
        logic [INDEX_OUT_W-1:0] index;
        logic [COUNT_OUT_W-1:0] removed;
        logic [COUNT_OUT_W-1:0] total;
    } bond_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    op_t                    s_operation = OP_FIND;
    logic [ATOM_W-1:0]      s_atom_a = '0;
    logic [ATOM_W-1:0]      s_atom_b = '0;
    logic                   s_virtual_flag = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    status_t                m_status;
    logic [INDEX_OUT_W-1:0] m_bond_index;
    logic [COUNT_OUT_W-1:0] m_removed_count;
    logic [COUNT_OUT_W-1:0] m_bond_total;

    // local copy of the bond table
    entry_t       bond_mem [TABLE_DEPTH];
    int unsigned  bond_cnt = 0;
    bond_result_t pending_results[$];

    logic [ATOM_W-1:0] atom_pool [32];
    int  err_cnt = 0;
    bit  idle_en = 1'b1;
    int  long_hold = 0;

    unordered_pair_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_atom_a       (s_atom_a),
        .s_atom_b       (s_atom_b),
        .s_virtual_flag (s_virtual_flag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bond_index   (m_bond_index),
        .m_removed_count(m_removed_count),
        .m_bond_total   (m_bond_total)
    );

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic int find_bond(logic [ATOM_W-1:0] a, logic [ATOM_W-1:0] b);
        for (int k = 0; k < bond_cnt; k++) begin
            if ((bond_mem[k].atom_a == a && bond_mem[k].atom_b == b) ||
                (bond_mem[k].atom_a == b && bond_mem[k].atom_b == a))
                return k;
        end
        return bond_cnt;
    endfunction

    // last entry moves into the freed slot
    function automatic void drop_bond(int slot);
        if (slot != bond_cnt - 1)
            bond_mem[slot] = bond_mem[bond_cnt - 1];
        bond_cnt--;
    endfunction

    function automatic bond_result_t apply_bond_op(op_t op, logic [ATOM_W-1:0] a,
                                                   logic [ATOM_W-1:0] b, logic v);
        bond_result_t res;
        int slot;
        int removed;
        res.status = STS_OK;
        res.index = '0;
        removed = 0;
        case (op)
            OP_FIND: begin
                slot = find_bond(a, b);
                if (slot < bond_cnt)
                    res.index = slot[INDEX_OUT_W-1:0];
                else
                    res.status = STS_NOT_FOUND;
            end
            OP_ADD: begin
                slot = find_bond(a, b);
                if (slot < bond_cnt) begin
                    res.status = STS_DUPLICATE;
                end else if (bond_cnt >= TABLE_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    bond_mem[bond_cnt] = '{virt: v, atom_b: b, atom_a: a};
                    res.index = bond_cnt[INDEX_OUT_W-1:0];
                    bond_cnt++;
                end
            end
            OP_DELETE: begin
                slot = find_bond(a, b);
                if (slot < bond_cnt) begin
                    res.index = slot[INDEX_OUT_W-1:0];
                    drop_bond(slot);
                    removed = 1;
                end else begin
                    res.status = STS_NOT_FOUND;
                end
            end
            default: begin
                // same slot is rechecked after each swap
                slot = 0;
                while (slot < bond_cnt) begin
                    if (bond_mem[slot].atom_a == a || bond_mem[slot].atom_b == a) begin
                        drop_bond(slot);
                        removed++;
                    end else begin
                        slot++;
                    end
                end
            end
        endcase
        res.removed = removed[COUNT_OUT_W-1:0];
        res.total = bond_cnt[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // ---------------- result checker ----------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        bond_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got status %0d",
                         $time, m_status);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if ($isunknown({m_status, m_bond_index, m_removed_count, m_bond_total})) begin
                    $display("%0t: unknown bits in result, expected %0d/%0d/%0d/%0d, got %b",
                             $time, want.status, want.index, want.removed, want.total,
                             {m_status, m_bond_index, m_removed_count, m_bond_total});
                    err_cnt++;
                end else begin
                    check_field("status", want.status, m_status);
                    check_field("bond_index", want.index, m_bond_index);
                    check_field("removed_count", want.removed, m_removed_count);
                    check_field("bond_total", want.total, m_bond_total);
                end
            end
        end
    end

    // ---------------- receiver ----------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                long_hold--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- sender ----------------
    task automatic send_word(op_t op, logic [ATOM_W-1:0] a, logic [ATOM_W-1:0] b, logic v);
        int gap;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_atom_a <= a;
        s_atom_b <= b;
        s_virtual_flag <= v;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_bond_op(op, a, b, v));
    endtask

    // drop valid after the last accepted word, then wait for every result
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic void fill_atom_pool();
        atom_pool[0] = '0;
        atom_pool[1] = '1;
        for (int k = 2; k < 32; k++)
            atom_pool[k] = ATOM_W'($urandom_range(0, (1 << ATOM_W) - 1));
    endfunction

    function automatic logic [ATOM_W-1:0] pick_atom();
        if ($urandom_range(0, 9) == 0)
            return ATOM_W'($urandom_range(0, (1 << ATOM_W) - 1));
        return atom_pool[$urandom_range(0, 31)];
    endfunction

    task automatic send_random_word();
        op_t op;
        logic [ATOM_W-1:0] a;
        logic [ATOM_W-1:0] b;
        int r;
        int slot;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_ADD;
        else if (r < 70)
            op = OP_FIND;
        else if (r < 92)
            op = OP_DELETE;
        else
            op = OP_DELETE_ALL;
        a = pick_atom();
        b = pick_atom();
        // mostly aim at a stored pair so finds and deletes hit
        if (op != OP_ADD && bond_cnt > 0 && $urandom_range(0, 9) < 6) begin
            slot = $urandom_range(0, bond_cnt - 1);
            if ($urandom_range(0, 1)) begin
                a = bond_mem[slot].atom_a;
                b = bond_mem[slot].atom_b;
            end else begin
                a = bond_mem[slot].atom_b;
                b = bond_mem[slot].atom_a;
            end
        end
        send_word(op, a, b, 1'($urandom_range(0, 1)));
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_word(OP_FIND, 12'd1, 12'd2, 1'b0);         // empty table
        send_word(OP_DELETE, 12'd1, 12'd2, 1'b0);
        send_word(OP_DELETE_ALL, 12'd1, 12'd0, 1'b0);
        send_word(OP_ADD, 12'd0, 12'd0, 1'b0);          // self pairs at the extremes
        send_word(OP_ADD, 12'hFFF, 12'hFFF, 1'b1);
        send_word(OP_ADD, 12'd0, 12'hFFF, 1'b1);
        send_word(OP_FIND, 12'hFFF, 12'd0, 1'b0);       // reversed order
        send_word(OP_FIND, 12'hFFF, 12'hFFF, 1'b0);
        send_word(OP_ADD, 12'hFFF, 12'd0, 1'b0);        // duplicate, reversed
        send_word(OP_FIND, 12'd0, 12'd1, 1'b0);
        send_word(OP_DELETE, 12'd1, 12'd2, 1'b1);
        send_word(OP_DELETE, 12'd0, 12'd0, 1'b0);       // last entry swaps into slot 0
        send_word(OP_FIND, 12'd0, 12'hFFF, 1'b0);
        send_word(OP_ADD, 12'd5, 12'd6, 1'b0);
        send_word(OP_ADD, 12'd7, 12'd5, 1'b1);
        send_word(OP_ADD, 12'd8, 12'd9, 1'b0);
        send_word(OP_ADD, 12'd5, 12'd5, 1'b1);
        send_word(OP_DELETE_ALL, 12'd5, 12'hABC, 1'b0); // swapped-in entry matches again
        send_word(OP_DELETE_ALL, 12'hABC, 12'd5, 1'b0); // no match
        send_word(OP_DELETE, 12'hFFF, 12'hFFF, 1'b0);
        send_word(OP_DELETE_ALL, 12'hFFF, 12'd0, 1'b1);
    endtask

    task automatic test_full_table();
        logic [ATOM_W-1:0] hub;
        hub = 12'hA5A;
        while (bond_cnt > 0)
            send_word(OP_DELETE_ALL, bond_mem[0].atom_a, 12'd0, 1'b0);
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_word(OP_ADD, hub, k[ATOM_W-1:0], k[0]);
        send_word(OP_ADD, 12'd1000, 12'd1001, 1'b1);    // table full
        send_word(OP_ADD, 12'd7, hub, 1'b0);            // duplicate wins over full
        send_word(OP_FIND, 12'd255, hub, 1'b0);
        send_word(OP_DELETE, 12'd3, hub, 1'b0);
        send_word(OP_ADD, hub, 12'd300, 1'b1);
        send_word(OP_DELETE_ALL, hub, 12'd0, 1'b0);     // removes every entry
    endtask

    task automatic test_backpressure();
        wait_drain();
        long_hold = 400;
        repeat (12) send_random_word();
        wait_drain();
        repeat (6) send_random_word();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            send_random_word();
            if (k % 250 == 249)
                wait_drain();
        end
    endtask

    task automatic test_no_idle(int count);
        idle_en = 1'b0;
        repeat (count) send_random_word();
    endtask

    initial begin
        fill_atom_pool();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(950);
        test_no_idle(100);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drain();
        repeat (600) @(posedge aclk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("%0t: timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
